// ===== hw/rtl/dpe_pkg.sv =====
// ============================================================================
// dpe_pkg - shared types and constants for the dynamic parameter encoder
// Holds field widths, fixed multipliers and masks, the job record that
// travels from the front end through the queue to the back end.
// ============================================================================
package dpe_pkg;

    // Field and datapath widths
    localparam int WORD_W  = 16;
    localparam int DIV_W   = 15;
    localparam int DVD_W   = 31;
    localparam int RAD_W   = 18;
    localparam int EXP_W   = 5;
    localparam int FRAC_W  = 8;
    localparam int CNT_W   = 5;
    localparam int PROD_W  = 28;
    localparam int ANG_PROD_W = 44;

    // One quotient bit per step over the whole dividend
    localparam int DIV_STEPS = DVD_W;

    // Job queue depth
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Angle scaling: floor(m * RECIP / 2^SHIFT) equals floor(m * 32768 / 1800)
    // for every magnitude m up to 2^15
    localparam logic [27:0] ANGLE_RECIP = 28'd152709949;
    localparam int          ANGLE_SHIFT = 23;

    // Fixed numbers of the encodings
    localparam logic [DIV_W-1:0]  SCALE_RESET = 15'd1250;
    localparam logic [12:0]       RADIUS_MUL  = 13'd6845;
    localparam logic [EXP_W-1:0]  EXP_START   = 5'd1;
    localparam logic [WORD_W-1:0] RADIUS_FLAG = 16'h8000;
    localparam logic [WORD_W-1:0] LEN_MASK    = 16'hfffe;
    localparam logic [WORD_W-1:0] ANGLE_MASK  = 16'hfff0;
    localparam logic [16:0]       ROUND_HALF  = 17'h00080;

    // Input mode codes
    typedef enum logic [1:0] {
        MODE_LENGTH = 2'd0,
        MODE_ANGLE  = 2'd1,
        MODE_RAW    = 2'd2,
        MODE_RADIUS = 2'd3
    } mode_t;

    // Work classes for the back end
    typedef enum logic [1:0] {
        JOB_PASS    = 2'd0,
        JOB_DIV_LEN = 2'd1,
        JOB_ANGLE   = 2'd2,
        JOB_NORM    = 2'd3
    } job_kind_t;

    // One classified item
    typedef struct packed {
        job_kind_t          kind;
        logic               neg;
        logic [DVD_W-1:0]   operand;
        logic [DIV_W-1:0]   divisor;
        logic [WORD_W-1:0]  word;
        logic               bad;
    } dpe_job_t;

    // Queue status toward both sides
    typedef struct packed {
        logic full;
        logic empty;
    } dpe_qstat_t;

endpackage

// ===== hw/rtl/dpe_front.sv =====
// ============================================================================
// dpe_front - input acceptance and classification
// Holds the scale divisor register, takes items, prepares operands (signed
// magnitude dividend, angle quotient, radius product) and pushes one job per
// item.
// ============================================================================
module dpe_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [dpe_pkg::DIV_W-1:0]    cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   mode,
    input  logic signed [dpe_pkg::WORD_W-1:0] value,
    input  dpe_pkg::dpe_qstat_t          q_stat,
    output logic                         push,
    output dpe_pkg::dpe_job_t            push_job
);
    import dpe_pkg::*;

    logic [DIV_W-1:0]      scale_reg;
    logic [DIV_W-1:0]      scale_next;
    logic [WORD_W-1:0]     mag;
    logic                  neg;
    logic [PROD_W-1:0]     rad_prod;
    logic [ANG_PROD_W-1:0] ang_prod;

    // Accept register writes at any time
    assign cfg_ready = 1'b1;

    always_comb
    begin
        scale_next = scale_reg;
        if (cfg_valid && cfg_ready)
        begin
            scale_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
        end
        else
        begin
            scale_reg <= scale_next;
        end
    end

    // Stall while the job queue has no room
    assign in_stall = q_stat.full;
    assign push     = in_valid && !q_stat.full;

    // Sign and magnitude of the value; the most negative value maps to 2^15
    assign neg = value[WORD_W-1];
    assign mag = neg ? (~value + 16'd1) : value;

    // Radius scaling product, only used for positive values
    assign rad_prod = PROD_W'(value[WORD_W-2:0]) * PROD_W'(RADIUS_MUL);

    // Angle quotient magnitude by reciprocal multiplication
    assign ang_prod = ANG_PROD_W'(mag) * ANG_PROD_W'(ANGLE_RECIP);

    // Classify the item into a job for the back end
    always_comb
    begin
        push_job         = '0;
        push_job.kind    = JOB_PASS;
        push_job.neg     = neg;
        push_job.divisor = scale_reg;
        push_job.word    = value;
        case (mode_t'(mode))
            MODE_LENGTH:
            begin
                push_job.kind    = JOB_DIV_LEN;
                push_job.operand = {5'b0, mag, 10'b0};
                push_job.divisor = (scale_reg == '0) ? DIV_W'(1) : scale_reg;
            end
            MODE_ANGLE:
            begin
                // Carry the low word of the quotient magnitude
                push_job.kind    = JOB_ANGLE;
                push_job.operand = DVD_W'(ang_prod[ANGLE_SHIFT +: WORD_W]);
            end
            MODE_RAW:
            begin
                push_job.kind = JOB_PASS;
                push_job.word = value;
            end
            MODE_RADIUS:
            begin
                // Zero or negative radius scales to zero or below
                if (neg || (value == '0))
                begin
                    push_job.kind = JOB_PASS;
                    push_job.word = '0;
                    push_job.bad  = 1'b1;
                end
                else
                begin
                    push_job.kind    = JOB_NORM;
                    push_job.operand = DVD_W'(rad_prod[PROD_W-1:10]);
                end
            end
            default:
            begin
                push_job.kind = JOB_PASS;
            end
        endcase
    end

endmodule

// ===== hw/rtl/dpe_queue.sv =====
// ============================================================================
// dpe_queue - short job queue between front and back end
// Two-entry FIFO of classified jobs; lets each side stall on its own.
// ============================================================================
module dpe_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  dpe_pkg::dpe_job_t   push_job,
    input  logic                pop,
    output dpe_pkg::dpe_job_t   head_job,
    output dpe_pkg::dpe_qstat_t q_stat
);
    import dpe_pkg::*;

    dpe_job_t            mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QPTR_W:0]     count_reg;
    logic [QPTR_W:0]     count_next;

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    assign head_job     = mem[rd_ptr_reg];
    assign q_stat.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/dpe_back.sv =====
// ============================================================================
// dpe_back - execution sequencer and output register
// Runs a bit-serial restoring divider for length jobs, an iterative
// normalizer for radius jobs, packs the final word and holds the result.
// ============================================================================
module dpe_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dpe_pkg::dpe_qstat_t           q_stat,
    input  dpe_pkg::dpe_job_t             head_job,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [dpe_pkg::WORD_W-1:0]    encoded_word,
    output logic                          invalid
);
    import dpe_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_NORM,
        S_DONE
    } state_t;

    state_t             state_reg,    state_next;
    job_kind_t          kind_reg,     kind_next;
    logic               neg_reg,      neg_next;
    logic [DVD_W-1:0]   dvd_reg,      dvd_next;
    logic [DIV_W-1:0]   dsr_reg,      dsr_next;
    logic [DIV_W-1:0]   rem_reg,      rem_next;
    logic [WORD_W-1:0]  quot_reg,     quot_next;
    logic [CNT_W-1:0]   cnt_reg,      cnt_next;
    logic [RAD_W-1:0]   rad_reg,      rad_next;
    logic [EXP_W-1:0]   exp_reg,      exp_next;
    logic [WORD_W-1:0]  pass_reg,     pass_next;
    logic               bad_reg,      bad_next;
    logic               out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]  out_word_reg, out_word_next;
    logic               out_bad_reg,  out_bad_next;

    logic [DIV_W:0]     rem_sh;
    logic [DIV_W:0]     rem_diff;
    logic               q_bit;
    logic [WORD_W-1:0]  q_signed;
    logic [16:0]        frac_sum;
    logic [FRAC_W-1:0]  frac;
    logic [WORD_W-1:0]  radius_word;
    logic [WORD_W-1:0]  final_word;
    logic               out_free;

    // Divider step: shift in one dividend bit, subtract when it fits
    assign rem_sh   = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_diff = rem_sh - {1'b0, dsr_reg};
    assign q_bit    = (rem_sh >= {1'b0, dsr_reg});

    // Restore the sign; only the low word of the quotient matters
    assign q_signed = neg_reg ? (~quot_reg + 16'd1) : quot_reg;

    // Round the fraction to 8 bits and clamp the carry case
    assign frac_sum    = {1'b0, rad_reg[WORD_W-1:0]} + ROUND_HALF;
    assign frac        = frac_sum[16] ? {FRAC_W{1'b1}} : frac_sum[15:8];
    assign radius_word = RADIUS_FLAG | {exp_reg[3:0], 12'b0} | {4'b0, frac, 4'b0};

    // Pack the word of the finished job
    always_comb
    begin
        case (kind_reg)
            JOB_DIV_LEN: final_word = (q_signed + 16'd1) & LEN_MASK;
            JOB_ANGLE:   final_word = q_signed & ANGLE_MASK;
            JOB_NORM:    final_word = radius_word;
            default:     final_word = pass_reg;
        endcase
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = (state_reg == S_IDLE) && !q_stat.empty;

    // Sequence the jobs
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        neg_next       = neg_reg;
        dvd_next       = dvd_reg;
        dsr_next       = dsr_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        cnt_next       = cnt_reg;
        rad_next       = rad_reg;
        exp_next       = exp_reg;
        pass_next      = pass_reg;
        bad_next       = bad_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        out_bad_next   = out_bad_reg;

        // Drop the held result once it is taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    kind_next = head_job.kind;
                    neg_next  = head_job.neg;
                    dvd_next  = head_job.operand;
                    dsr_next  = head_job.divisor;
                    rem_next  = '0;
                    quot_next = '0;
                    cnt_next  = '0;
                    rad_next  = head_job.operand[RAD_W-1:0];
                    exp_next  = EXP_START;
                    pass_next = head_job.word;
                    bad_next  = head_job.bad;
                    case (head_job.kind)
                        JOB_PASS: state_next = S_DONE;
                        JOB_NORM: state_next = S_NORM;
                        JOB_ANGLE:
                        begin
                            // Quotient is already computed up front
                            quot_next  = head_job.operand[WORD_W-1:0];
                            state_next = S_DONE;
                        end
                        default:  state_next = S_DIV;
                    endcase
                end
            end
            S_DIV:
            begin
                rem_next  = q_bit ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
                quot_next = {quot_reg[WORD_W-2:0], q_bit};
                dvd_next  = {dvd_reg[DVD_W-2:0], 1'b0};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_NORM:
            begin
                // Double below 1.0, halve at 2.0 or above
                if (rad_reg[RAD_W-1:RAD_W-2] == 2'b00)
                begin
                    rad_next = {rad_reg[RAD_W-2:0], 1'b0};
                    exp_next = exp_reg + 1'b1;
                end
                else if (rad_reg[RAD_W-1])
                begin
                    rad_next = {1'b0, rad_reg[RAD_W-1:1]};
                    exp_next = exp_reg - 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = final_word;
                    out_bad_next   = bad_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, work registers and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= JOB_PASS;
            neg_reg       <= 1'b0;
            dvd_reg       <= '0;
            dsr_reg       <= '0;
            rem_reg       <= '0;
            quot_reg      <= '0;
            cnt_reg       <= '0;
            rad_reg       <= '0;
            exp_reg       <= '0;
            pass_reg      <= '0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
            out_bad_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            neg_reg       <= neg_next;
            dvd_reg       <= dvd_next;
            dsr_reg       <= dsr_next;
            rem_reg       <= rem_next;
            quot_reg      <= quot_next;
            cnt_reg       <= cnt_next;
            rad_reg       <= rad_next;
            exp_reg       <= exp_next;
            pass_reg      <= pass_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
            out_word_reg  <= out_word_next;
            out_bad_reg   <= out_bad_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign encoded_word = out_word_reg;
    assign invalid      = out_bad_reg;

endmodule

// ===== hw/rtl/dynamic_parameter_encoder.sv =====
// ============================================================================
// dynamic_parameter_encoder - display parameter word encoder
// Turns a signed value and a mode into one 16-bit encoded parameter word.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall, mode, value): a transaction moves
//   when in_valid is high and in_stall is low. Output channel (out_valid /
//   out_stall, encoded_word, invalid): one result transaction per input,
//   in input order.
//   Config channel (cfg_valid / cfg_ready, cfg_data): writes the scale
//   divisor used by length items; cfg_ready is always high. Write
//   it only while no item is in flight.
//   Path from the input to a valid result: raw data, angle and
//   non-positive radius jobs go from the queue to the S_DONE state; radius
//   jobs first pass S_NORM (one normalizing shift per step, up to 14, plus a
//   final check); length jobs pass S_DIV, the divider taking 31 steps.
//   The back-end sequencer handles one item at a time while a two-entry
//   queue keeps accepting new ones until it is full.
//   Reset: the queue empties, the output register clears and the divisor
//   returns to 1250.
//   Output stall: the result is held stable; the back end finishes the
//   next item and waits, and the input stalls once the queue is full.
// ============================================================================
module dynamic_parameter_encoder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dpe_pkg::DIV_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        mode,
    input  logic signed [dpe_pkg::WORD_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [dpe_pkg::WORD_W-1:0]        encoded_word,
    output logic                              invalid
);
    import dpe_pkg::*;

    dpe_qstat_t q_stat;
    dpe_job_t   push_job;
    dpe_job_t   head_job;
    logic       push;
    logic       pop;

    // Classify incoming items
    dpe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .value     (value),
        .q_stat    (q_stat),
        .push      (push),
        .push_job  (push_job)
    );

    // Buffer classified jobs
    dpe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_stat   (q_stat)
    );

    // Execute jobs and hold results
    dpe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .head_job     (head_job),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .encoded_word (encoded_word),
        .invalid      (invalid)
    );

endmodule

// ===== hw/rtl/dpe_checker.sv =====
// ============================================================================
// dpe_checker - port-level checks for the dynamic parameter encoder
// Tracks transactions in flight and checks result hold, capacity and encoding
// rules visible at the top-level ports.
// ============================================================================
module dpe_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [dpe_pkg::WORD_W-1:0] encoded_word,
    input logic                       invalid
);
    import dpe_pkg::*;

    localparam logic [2:0] MAX_IN_FLIGHT = 3'(QUEUE_DEPTH + 2);

    logic       in_acc;
    logic       out_acc;
    logic [2:0] pending_reg;
    logic [2:0] pending_next;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    // Count transactions accepted but not yet delivered
    always_comb
    begin
        case ({in_acc, out_acc})
            2'b10:   pending_next = pending_reg + 1'b1;
            2'b01:   pending_next = pending_reg - 1'b1;
            default: pending_next = pending_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(encoded_word) && $stable(invalid))
        else $error("stalled result changed");

    // An invalid radius carries a zero word
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && invalid |-> encoded_word == '0)
        else $error("invalid result with nonzero word");

    // No result without an accepted input
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != '0)
        else $error("result without pending transaction");

    // Full pipeline must stall the input
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == MAX_IN_FLIGHT |-> in_stall)
        else $error("input accepted beyond capacity");

endmodule

bind dynamic_parameter_encoder dpe_checker u_dpe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .encoded_word (encoded_word),
    .invalid      (invalid)
);
